>>> rtl/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg: shared definitions for the quadratic probe hash insert block
// Field widths, register reset value and the memory control group.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam int KEY_W        = 31;
  localparam int IDX_W        = 14;
  localparam int CFG_W        = 15;
  localparam int CNT_W        = $clog2(KEY_W);
  localparam int DEPTH_DEFAULT = 16384;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 15'd16384;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } qph_mem_ctl_t;

endpackage

>>> rtl/qph_if.sv
// ----------------------------------------------------------------------------
// qph_if: valid/ready channels for keys and insert results
// One interface per channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface qph_key_if;
  import qph_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

interface qph_result_if;
  import qph_pkg::*;

  logic             valid;
  logic             ready;
  logic             placed;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output placed, output slot_index, input ready);
  modport sink (input valid, input placed, input slot_index, output ready);
endinterface

>>> rtl/qph_modadd.sv
// ----------------------------------------------------------------------------
// qph_modadd: shared modular adder
// Computes (a + b + cin) mod m for a + b + cin below twice m.
// ----------------------------------------------------------------------------
module qph_modadd #(
  parameter int W = 15
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         cin,
  input  logic [W-1:0] m,
  output logic [W-1:0] y
);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
  assign diff = sum - {1'b0, m};
  assign y    = (sum >= {1'b0, m}) ? diff[W-1:0] : sum[W-1:0];

endmodule

>>> rtl/qph_slot_store.sv
// ----------------------------------------------------------------------------
// qph_slot_store: slot occupancy memory
// One bit per slot, registered read, clearing sweep after reset.
// ----------------------------------------------------------------------------
module qph_slot_store #(
  parameter int DEPTH = 16384
) (
  input  logic                      clk,
  input  logic                      rst,
  input  qph_pkg::qph_mem_ctl_t     ctl,
  input  logic [$clog2(DEPTH)-1:0]  addr,
  output logic                      rd_data,
  output logic                      clear_busy
);
  import qph_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic           mem [DEPTH];
  logic [AW-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (ctl.wr_en) begin
      mem[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> rtl/quadratic_probe_hash_insert_core.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_insert_core: hash insert with quadratic probing
// Flow: key mod size is formed bit by bit in S_DIV, then each probe passes
// S_POS and S_CHECK, plus S_STEP when the slot is taken; S_EMIT loads the
// result register, waiting while a held result is unaccepted. Keys are taken
// only in S_IDLE; reset clears all TABLE_DEPTH slots in a sweep, keys wait.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_insert_core #(
  parameter int TABLE_DEPTH = qph_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [qph_pkg::CFG_W-1:0] cfg_wdata,
  qph_key_if.sink                   keys,
  qph_result_if.source              results
);
  import qph_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_POS,
    S_CHECK,
    S_STEP,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] table_size;
  logic [SW-1:0]    size_eff;
  logic [SW-1:0]    size_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] bit_cnt;
  logic [AW-1:0]    home;
  logic [AW-1:0]    sq;
  logic [AW-1:0]    d;
  logic [AW-1:0]    pos;
  logic [SW-1:0]    i;
  logic             res_placed;
  logic [AW-1:0]    res_pos;
  logic             out_valid;
  logic             out_placed;
  logic [IDX_W-1:0] out_index;

  logic [SW-1:0]    op_a;
  logic [SW-1:0]    op_b;
  logic             op_cin;
  logic [SW-1:0]    unit_y;
  logic [AW-1:0]    unit_r;
  logic             last_probe;

  qph_mem_ctl_t     mem_ctl;
  logic [AW-1:0]    mem_addr;
  logic             rd_data;
  logic             clear_busy;

  always_comb begin
    if (table_size == '0) begin
      size_eff = SW'(1);
    end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      size_eff = SW'(TABLE_DEPTH);
    end else begin
      size_eff = SW'(table_size);
    end
  end

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_cin = 1'b0;
    case (state)
      S_DIV: begin
        op_a   = SW'(home);
        op_b   = SW'(home);
        op_cin = key_q[KEY_W-1];
      end
      S_POS: begin
        op_a = SW'(home);
        op_b = SW'(sq);
      end
      S_CHECK: begin
        op_a = SW'(sq);
        op_b = SW'(d);
      end
      S_STEP: begin
        op_a   = SW'(d);
        op_b   = SW'(1);
        op_cin = 1'b1;
      end
      default: begin
        op_a   = '0;
      end
    endcase
  end

  qph_modadd #(
    .W (SW)
  ) u_modadd (
    .a   (op_a),
    .b   (op_b),
    .cin (op_cin),
    .m   (size_q),
    .y   (unit_y)
  );

  assign unit_r     = AW'(unit_y);
  assign last_probe = ((SW+1)'(i) + 1'b1) == (SW+1)'(size_q);

  always_comb begin
    mem_ctl.rd_en = (state == S_POS);
    mem_ctl.wr_en = (state == S_CHECK) && !rd_data;
    mem_addr      = (state == S_POS) ? unit_r : pos;
  end

  qph_slot_store #(
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mem_ctl),
    .addr       (mem_addr),
    .rd_data    (rd_data),
    .clear_busy (clear_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (keys.valid && keys.ready) begin
            key_q   <= keys.key;
            size_q  <= size_eff;
            home    <= '0;
            bit_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          home    <= unit_r;
          key_q   <= {key_q[KEY_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == CNT_W'(KEY_W - 1)) begin
            sq    <= '0;
            d     <= AW'(1);
            i     <= '0;
            state <= S_POS;
          end
        end
        S_POS: begin
          pos   <= unit_r;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!rd_data) begin
            res_placed <= 1'b1;
            res_pos    <= pos;
            state      <= S_EMIT;
          end else begin
            sq    <= unit_r;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          d <= unit_r;
          i <= i + 1'b1;
          if (last_probe) begin
            res_placed <= 1'b0;
            res_pos    <= '0;
            state      <= S_EMIT;
          end else begin
            state <= S_POS;
          end
        end
        S_EMIT: begin
          if (!out_valid || results.ready) begin
            out_valid  <= 1'b1;
            out_placed <= res_placed;
            out_index  <= IDX_W'(res_pos);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign keys.ready         = (state == S_IDLE) && !clear_busy;
  assign results.valid      = out_valid;
  assign results.placed     = out_placed;
  assign results.slot_index = out_index;

`ifndef SYNTHESIS
  a_no_key_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !keys.ready)
    else $error("key accepted during occupancy clear");

  a_unplaced_index_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.placed) |-> (results.slot_index == '0))
    else $error("slot index nonzero on failed insert");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ((SW+1)'(pos) < (SW+1)'(size_q)))
    else $error("probe position outside table");

  a_write_marks_free: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |=> (state == S_EMIT) && res_placed)
    else $error("slot written without a placed result");
`endif

endmodule
